@@ hdl/n2da_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2da_pkg
// shared types and constants for the decimal ascii formatter
// ----------------------------------------------------------------------------
package n2da_pkg;

    localparam int VALUE_BITS          = 32;
    localparam int DEF_MAX_INT_DIGITS  = 10;
    localparam int DEF_FRACTION_BITS   = 16;
    localparam int CONV_CNT_BITS       = $clog2(VALUE_BITS);

    localparam logic [1:0] OP_UNSIGNED = 2'd0;
    localparam logic [1:0] OP_SIGNED   = 2'd1;
    localparam logic [1:0] OP_FIXED    = 2'd2;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_POINT    = 8'h2e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONVERT,
        ST_DIGITS,
        ST_POINT,
        ST_FRAC
    } t_state;

    typedef struct packed {
        logic load;
        logic convert;
        logic shift_digit;
        logic emit_sign;
        logic emit_digit;
        logic emit_point;
        logic emit_frac;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic fixed;
        logic top_zero;
        logic places_zero;
        logic places_last;
    } t_status;

endpackage
`default_nettype wire

@@ hdl/n2da_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2da_datapath
// magnitude, binary to bcd shifter, fraction times ten and output register
// ----------------------------------------------------------------------------
module n2da_datapath
    import n2da_pkg::*;
#(
    parameter int MAX_INT_DIGITS = DEF_MAX_INT_DIGITS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [15:0]           i_fraction,
    input  wire logic [3:0]            i_places,
    output logic                       o_strobe,
    output logic [7:0]                 o_character,
    output logic                       o_last
);

    localparam int BCD_BITS   = 4 * MAX_INT_DIGITS;
    localparam int WHOLE_BITS = VALUE_BITS + FRACTION_BITS;

    logic [VALUE_BITS-1:0]    r_bin,  n_bin;
    logic [BCD_BITS-1:0]      r_bcd,  n_bcd;
    logic [FRACTION_BITS-1:0] r_frac, n_frac;
    logic [3:0]               r_places, n_places;
    logic                     r_neg, n_neg;
    logic                     r_fixed, n_fixed;
    logic                     r_strobe, n_strobe;
    logic [7:0]               r_char, n_char;
    logic                     r_last, n_last;

    logic [FRACTION_BITS+15:0] frac_ext;
    logic [FRACTION_BITS-1:0]  frac_in;
    logic [WHOLE_BITS-1:0]     whole;
    logic [WHOLE_BITS-1:0]     whole_neg;
    logic [BCD_BITS-1:0]       bcd_adj;
    logic [FRACTION_BITS+3:0]  frac_x10;
    logic                      is_signed;
    logic                      is_fixed;

    always_comb begin
        frac_ext  = {{FRACTION_BITS{1'b0}}, i_fraction};
        frac_in   = frac_ext[FRACTION_BITS-1:0];
        whole     = {i_value, frac_in};
        whole_neg = ~whole + WHOLE_BITS'(1);
        case (i_opcode)
            OP_SIGNED: begin
                is_signed = 1'b1;
                is_fixed  = 1'b0;
            end
            OP_FIXED: begin
                is_signed = 1'b1;
                is_fixed  = 1'b1;
            end
            default: begin
                is_signed = 1'b0;
                is_fixed  = 1'b0;
            end
        endcase
    end

    // add 3 to every bcd digit above four before the shift
    always_comb begin
        for (int d = 0; d < MAX_INT_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign frac_x10 = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_frac   = r_frac;
        n_places = r_places;
        n_neg    = r_neg;
        n_fixed  = r_fixed;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;

        if (i_cmd.load) begin
            n_neg    = is_signed & i_value[VALUE_BITS-1];
            n_fixed  = is_fixed;
            n_places = i_places;
            n_bcd    = '0;
            if (is_fixed && i_value[VALUE_BITS-1]) begin
                n_bin  = whole_neg[WHOLE_BITS-1:FRACTION_BITS];
                n_frac = whole_neg[FRACTION_BITS-1:0];
            end else if (is_signed && i_value[VALUE_BITS-1]) begin
                n_bin  = ~i_value + VALUE_BITS'(1);
                n_frac = frac_in;
            end else begin
                n_bin  = i_value;
                n_frac = frac_in;
            end
        end

        if (i_cmd.convert) begin
            n_bcd = {bcd_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end

        if (i_cmd.shift_digit) begin
            n_bcd = {r_bcd[BCD_BITS-5:0], 4'd0};
        end

        if (i_cmd.emit_sign) begin
            n_strobe = 1'b1;
            n_char   = CH_MINUS;
        end else if (i_cmd.emit_digit) begin
            n_strobe = 1'b1;
            n_char   = CH_ZERO | {4'd0, r_bcd[BCD_BITS-1 -: 4]};
        end else if (i_cmd.emit_point) begin
            n_strobe = 1'b1;
            n_char   = CH_POINT;
        end else if (i_cmd.emit_frac) begin
            n_strobe = 1'b1;
            n_char   = CH_ZERO | {4'd0, frac_x10[FRACTION_BITS+3:FRACTION_BITS]};
            n_frac   = frac_x10[FRACTION_BITS-1:0];
            n_places = r_places - 4'd1;
        end
        n_last = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_frac   <= n_frac;
        r_places <= n_places;
        r_neg    <= n_neg;
        r_fixed  <= n_fixed;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    always_comb begin
        o_status.neg         = r_neg;
        o_status.fixed       = r_fixed;
        o_status.top_zero    = (r_bcd[BCD_BITS-1 -: 4] == 4'd0);
        o_status.places_zero = (r_places == 4'd0);
        o_status.places_last = (r_places == 4'd1);
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
`default_nettype wire

@@ hdl/n2da_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2da_ctrl
// sequencer: sign, conversion, integer digits, point, fraction digits
// ----------------------------------------------------------------------------
module n2da_ctrl
    import n2da_pkg::*;
#(
    parameter int MAX_INT_DIGITS = DEF_MAX_INT_DIGITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam int DIG_BITS = $clog2(MAX_INT_DIGITS);

    t_state                   r_state, n_state;
    logic [CONV_CNT_BITS-1:0] r_conv,  n_conv;
    logic [DIG_BITS-1:0]      r_dig,   n_dig;
    logic                     r_started, n_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_conv    <= '0;
            r_dig     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_conv    <= n_conv;
            r_dig     <= n_dig;
            r_started <= n_started;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_conv    = r_conv;
        n_dig     = r_dig;
        n_started = r_started;
        o_cmd     = '0;
        busy      = 1'b1;

        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SIGN;
                end
            end
            ST_SIGN: begin
                o_cmd.emit_sign = i_status.neg;
                n_conv          = '0;
                n_state         = ST_CONVERT;
            end
            ST_CONVERT: begin
                o_cmd.convert = 1'b1;
                n_conv        = r_conv + CONV_CNT_BITS'(1);
                if (r_conv == CONV_CNT_BITS'(VALUE_BITS - 1)) begin
                    n_dig     = DIG_BITS'(MAX_INT_DIGITS - 1);
                    n_started = 1'b0;
                    n_state   = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                // leading zeros are skipped, the units digit always prints
                o_cmd.shift_digit = 1'b1;
                if (r_started || !i_status.top_zero || (r_dig == '0)) begin
                    o_cmd.emit_digit = 1'b1;
                    n_started        = 1'b1;
                end
                if (r_dig == '0) begin
                    o_cmd.last = !i_status.fixed;
                    n_state    = i_status.fixed ? ST_POINT : ST_IDLE;
                end else begin
                    n_dig = r_dig - DIG_BITS'(1);
                end
            end
            ST_POINT: begin
                o_cmd.emit_point = 1'b1;
                o_cmd.last       = i_status.places_zero;
                n_state          = i_status.places_zero ? ST_IDLE : ST_FRAC;
            end
            ST_FRAC: begin
                o_cmd.emit_frac = 1'b1;
                o_cmd.last      = i_status.places_last;
                if (i_status.places_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/number_to_decimal_ascii.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_decimal_ascii
// formats one unsigned, signed or fixed point number as decimal ascii text
// ----------------------------------------------------------------------------
// the minus sign comes first, from ST_SIGN; the digits follow the shift-add-3
//   bcd loop in ST_CONVERT (one bit a cycle), then come the integer digits
//   from MAX_INT_DIGITS bcd digits, then point and fraction digits one a cycle
// one number at a time; start is taken again once busy falls back in ST_IDLE
// results are strobed for one cycle, cannot be stalled; sync active low reset
module number_to_decimal_ascii
    import n2da_pkg::*;
#(
    parameter int MAX_INT_DIGITS = DEF_MAX_INT_DIGITS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [15:0]           i_fraction,
    input  wire logic [3:0]            i_places,
    output logic                       o_strobe,
    output logic [7:0]                 o_character,
    output logic                       o_last
);

    t_cmd    cmd;
    t_status status;

    n2da_ctrl #(
        .MAX_INT_DIGITS(MAX_INT_DIGITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    n2da_datapath #(
        .MAX_INT_DIGITS(MAX_INT_DIGITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_fraction  (i_fraction),
        .i_places    (i_places),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
